/* src/bap_pkg.sv */
package bap_pkg;

  // Sizing of the stores and the page granule.
  localparam int BLOCK_ENTRIES    = 16;
  localparam int PAGE_STACK_DEPTH = 16;
  localparam int PAGE_BYTES       = 4096;

  localparam int BIW = $clog2(BLOCK_ENTRIES);
  localparam int SIW = $clog2(PAGE_STACK_DEPTH);
  localparam int SCW = $clog2(PAGE_STACK_DEPTH + 1);

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_BLK_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BLK_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PG_ALLOC  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PG_FREE   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           load;
    logic           scan_rd;
    logic [BIW-1:0] scan_idx;
    logic           pg_rd;
    logic           commit;
  } ctrl_cmd_t;

endpackage

/* src/block_and_page_allocator_core.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_cmd, in_req_size, in_req_addr
// out_      output     out_valid/out_ready  out_result_addr, out_status, out_reused
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// Block commands read the table memory one entry per cycle and check every
// entry. Page allocate does one stack memory read; page free reads none.
// Reset clears all valid bits and the stack count; no clearing pass is needed.
// A result waits in the output register; the next beat is accepted meanwhile
// and its result is held back until the output register is free.
module block_and_page_allocator_core
  import bap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [SIZE_W-1:0]    in_req_size,
  input  logic [ADDR_W-1:0]    in_req_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_result_addr,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_reused,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  ctrl_cmd_t cmd;

  // Sequencer.
  bap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Tables, pointers and result register.
  bap_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_cmd          (in_cmd),
    .in_req_size     (in_req_size),
    .in_req_addr     (in_req_addr),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_result_addr (out_result_addr),
    .out_status      (out_status),
    .out_reused      (out_reused)
  );

endmodule

/* src/bap_ctrl.sv */
module bap_ctrl
  import bap_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output ctrl_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PGRD  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [BIW-1:0] LAST_IDX = BIW'(BLOCK_ENTRIES - 1);

  logic [2:0]     state_r, state_nxt;
  logic [BIW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing of one command: decode, then a table scan or a stack read where needed, result.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.scan_idx = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          unique case (in_cmd)
            CMD_BLK_ALLOC, CMD_BLK_FREE: state_nxt = S_SCAN;
            CMD_PG_ALLOC:                state_nxt = S_PGRD;
            CMD_PG_FREE:                 state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + BIW'(1);
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_PGRD: begin
        cmd.pg_rd = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result beat stays until it is taken.
  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/bap_dp.sv */
module bap_dp
  import bap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [SIZE_W-1:0]    in_req_size,
  input  logic [ADDR_W-1:0]    in_req_addr,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  output logic [ADDR_W-1:0]    out_result_addr,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_reused
);

  localparam int ENT_W = ADDR_W + SIZE_W;

  // Latched command.
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;

  // Pointers and limits.
  logic [ADDR_W-1:0] heap_top_r, heap_top_nxt;
  logic [ADDR_W-1:0] heap_limit_r, heap_limit_nxt;
  logic [ADDR_W-1:0] page_top_r, page_top_nxt;
  logic [ADDR_W-1:0] page_limit_r, page_limit_nxt;

  // Block table: address and size in memory, valid and in-use bits in flops.
  logic [ENT_W-1:0]         blk_mem [BLOCK_ENTRIES];
  logic [ENT_W-1:0]         blk_q_r;
  logic [BLOCK_ENTRIES-1:0] valid_r, valid_nxt;
  logic [BLOCK_ENTRIES-1:0] used_r, used_nxt;
  logic                     blk_we;

  // Scan tracking.
  logic              chk_vld_r;
  logic [BIW-1:0]    chk_idx_r;
  logic              hit_r;
  logic [BIW-1:0]    hit_idx_r;
  logic [ADDR_W-1:0] hit_addr_r;
  logic              slot_r;
  logic [BIW-1:0]    slot_idx_r;
  logic              ent_valid, ent_used, match;
  logic [ADDR_W-1:0] q_addr;
  logic [SIZE_W-1:0] q_size;

  // Free-page stack.
  logic [ADDR_W-1:0] stk_mem [PAGE_STACK_DEPTH];
  logic [ADDR_W-1:0] stk_q_r;
  logic [SCW-1:0]    count_r, count_nxt;
  logic [SCW-1:0]    count_dec;
  logic              stk_we;

  // Bump arithmetic, done without wrap.
  logic [ADDR_W:0] heap_end, page_end;

  // Result payload.
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_reused_r, res_reused_nxt;

  assign q_addr    = blk_q_r[ENT_W-1:SIZE_W];
  assign q_size    = blk_q_r[SIZE_W-1:0];
  assign ent_valid = valid_r[chk_idx_r];
  assign ent_used  = used_r[chk_idx_r];
  assign count_dec = count_r - SCW'(1);
  assign heap_end  = {1'b0, heap_top_r} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, size_r};
  assign page_end  = {1'b0, page_top_r} + (ADDR_W + 1)'(PAGE_BYTES);

  // An allocate looks for a free entry of the same size, a free for a used
  // entry with the same address.
  always_comb begin
    if (cmd_r == CMD_BLK_ALLOC) begin
      match = ent_valid && !ent_used && (q_size == size_r);
    end else begin
      match = ent_valid && ent_used && (q_addr == addr_r);
    end
  end

  // Outcome of the command, applied on commit.
  always_comb begin
    heap_top_nxt   = heap_top_r;
    heap_limit_nxt = heap_limit_r;
    page_top_nxt   = page_top_r;
    page_limit_nxt = page_limit_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    blk_we         = 1'b0;
    stk_we         = 1'b0;
    res_addr_nxt   = '0;
    res_status_nxt = ST_OK;
    res_reused_nxt = 1'b0;
    unique case (cmd_r)
      CMD_BLK_ALLOC: begin
        priority if (hit_r) begin
          used_nxt[hit_idx_r] = 1'b1;
          res_addr_nxt        = hit_addr_r;
          res_reused_nxt      = 1'b1;
        end else if (!slot_r) begin
          res_status_nxt = ST_TABLE_FULL;
        end else if (heap_end > {1'b0, heap_limit_r}) begin
          res_status_nxt = ST_EXHAUSTED;
        end else begin
          valid_nxt[slot_idx_r] = 1'b1;
          used_nxt[slot_idx_r]  = 1'b1;
          blk_we                = 1'b1;
          res_addr_nxt          = heap_top_r;
          heap_top_nxt          = heap_end[ADDR_W-1:0];
        end
      end
      CMD_BLK_FREE: begin
        if (hit_r) begin
          used_nxt[hit_idx_r] = 1'b0;
        end else begin
          res_status_nxt = ST_UNKNOWN;
        end
      end
      CMD_PG_ALLOC: begin
        priority if (count_r != '0) begin
          count_nxt      = count_dec;
          res_addr_nxt   = stk_q_r;
          res_reused_nxt = 1'b1;
        end else if (page_end > {1'b0, page_limit_r}) begin
          res_status_nxt = ST_EXHAUSTED;
        end else begin
          res_addr_nxt = page_top_r;
          page_top_nxt = page_end[ADDR_W-1:0];
        end
      end
      CMD_PG_FREE: begin
        if (count_r >= SCW'(PAGE_STACK_DEPTH)) begin
          res_status_nxt = ST_STACK_FULL;
        end else begin
          stk_we    = 1'b1;
          count_nxt = count_r + SCW'(1);
        end
      end
    endcase
    if (!cmd.commit) begin
      heap_top_nxt = heap_top_r;
      page_top_nxt = page_top_r;
      valid_nxt    = valid_r;
      used_nxt     = used_r;
      count_nxt    = count_r;
      blk_we       = 1'b0;
      stk_we       = 1'b0;
    end
    // The user must write registers only while no command is in flight; the block does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:  heap_top_nxt   = cfg_wdata;
        CFG_HEAP_LIMIT: heap_limit_nxt = cfg_wdata;
        CFG_PAGE_BASE:  page_top_nxt   = cfg_wdata;
        CFG_PAGE_LIMIT: page_limit_nxt = cfg_wdata;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_top_r   <= '0;
      heap_limit_r <= '1;
      page_top_r   <= '0;
      page_limit_r <= '1;
      valid_r      <= '0;
      used_r       <= '0;
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      slot_r       <= 1'b0;
    end else begin
      heap_top_r   <= heap_top_nxt;
      heap_limit_r <= heap_limit_nxt;
      page_top_r   <= page_top_nxt;
      page_limit_r <= page_limit_nxt;
      valid_r      <= valid_nxt;
      used_r       <= used_nxt;
      count_r      <= count_nxt;
      chk_vld_r    <= cmd.scan_rd;
      if (cmd.load) begin
        hit_r  <= 1'b0;
        slot_r <= 1'b0;
      end else if (chk_vld_r) begin
        if (match && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!ent_valid && !slot_r) begin
          slot_r <= 1'b1;
        end
      end
    end
  end

  // Scan payload: lowest match and lowest empty slot.
  always_ff @(posedge clk) begin
    chk_idx_r <= cmd.scan_idx;
    if (chk_vld_r && match && !hit_r) begin
      hit_idx_r  <= chk_idx_r;
      hit_addr_r <= q_addr;
    end
    if (chk_vld_r && !ent_valid && !slot_r) begin
      slot_idx_r <= chk_idx_r;
    end
  end

  // Command latch and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      size_r <= in_req_size;
      addr_r <= in_req_addr;
    end
    if (cmd.commit) begin
      res_addr_r   <= res_addr_nxt;
      res_status_r <= res_status_nxt;
      res_reused_r <= res_reused_nxt;
    end
  end

  // Block table memory.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[slot_idx_r] <= {heap_top_r, size_r};
    end
    if (cmd.scan_rd) begin
      blk_q_r <= blk_mem[cmd.scan_idx];
    end
  end

  // Free-page stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[count_r[SIW-1:0]] <= addr_r;
    end
    if (cmd.pg_rd) begin
      stk_q_r <= stk_mem[count_dec[SIW-1:0]];
    end
  end

  assign out_result_addr = res_addr_r;
  assign out_status      = res_status_r;
  assign out_reused      = res_reused_r;

endmodule
